// ----- rtl/quadratic_fit_range_eval_top_assert.svh -----
// Assertion macros used by the quadratic fit controller.
`ifndef QUADRATIC_FIT_RANGE_EVAL_TOP_ASSERT_SVH
`define QUADRATIC_FIT_RANGE_EVAL_TOP_ASSERT_SVH

// Same-cycle implication.
`define QFRE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qfre assertion failed");

// Next-cycle implication.
`define QFRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qfre assertion failed");

`endif

// ----- rtl/qfre_pkg.sv -----
// Shared constants, command and status types of the quadratic fit block.
`default_nettype none
package qfre_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int FRAC_BITS      = 8;
  localparam int SLOPE_FRAC     = 46 - COORD_WIDTH;
  localparam int SUM_FRAC       = 14;
  localparam int OUTER_SH       = SLOPE_FRAC - SUM_FRAC;
  localparam int DEF_MAX_POINTS = 64;
  localparam int DIFF_W         = COORD_WIDTH + 1;
  localparam int WIDE_W         = 64;
  localparam int HALF_W         = WIDE_W / 2;
  localparam int PROD_W         = WIDE_W + COORD_WIDTH;
  localparam int Y_W            = WIDE_W - SUM_FRAC;
  localparam int DIV_STEPS      = WIDE_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W      = 3;
  localparam int CLAMP_BIT      = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_M_SETUP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_SUM,
    OP_MUL_FIN,
    OP_INNER,
    OP_ROUND,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SEL_AB = 2'd0,
    SEL_BC = 2'd1,
    SEL_SQ = 2'd2
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t div_sel;
    logic     second;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic count_zero;
    logic out_free;
    logic last_point;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/qfre_datapath.sv -----
// Datapath: point registers, serial divider, split multiplier, output register.
`default_nettype none
module qfre_datapath import qfre_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic signed [COORD_WIDTH-1:0] start_x,
  input  wire logic signed [COORD_WIDTH-1:0] end_x,
  input  wire logic                          out_stall,
  input  wire cmd_t                          cmd,
  output status_t                            status,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      x_value,
  output logic signed [COORD_WIDTH-1:0]      y_value,
  output logic                               last,
  output logic                               singular,
  output logic                               truncated
);

  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int CNT_RAW_W = DIFF_W - FRAC_BITS;
  localparam logic [PROD_W-1:0] CLAMP_LIM = PROD_W'(1) << CLAMP_BIT;
  localparam logic signed [Y_W-1:0] Y_HI =
    {{(Y_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_LO =
    {{(Y_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (SUM_FRAC - 1);
  localparam logic signed [COORD_WIDTH-1:0] X_STEP = COORD_WIDTH'(1) <<< FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] pa_x, pa_y, pb_x, pb_y, pc_x, pc_y;
  logic signed [WIDE_W-1:0]      s_ab, s_bc, cs, inner, res;
  logic [WIDE_W-1:0]             quo;
  logic [COORD_WIDTH-1:0]        rem, dvsr;
  logic                          div_neg;
  logic [WIDE_W-1:0]             a_mag;
  logic [COORD_WIDTH-1:0]        b_mag;
  logic                          mneg;
  logic [HALF_W+COORD_WIDTH-1:0] plo, phi;
  logic [PROD_W-1:0]             prod;
  logic signed [Y_W-1:0]         y_round;
  logic signed [COORD_WIDTH-1:0] cur_x;
  logic [CNT_W-1:0]              left;
  logic                          trunc_flag;

  // point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pa_x <= '0;
      pa_y <= '0;
      pb_x <= COORD_WIDTH'(1) <<< FRAC_BITS;
      pb_y <= '0;
      pc_x <= COORD_WIDTH'(2) <<< FRAC_BITS;
      pc_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_X: pa_x <= cfg_data;
        REG_A_Y: pa_y <= cfg_data;
        REG_B_X: pb_x <= cfg_data;
        REG_B_Y: pb_y <= cfg_data;
        REG_C_X: pc_x <= cfg_data;
        REG_C_Y: pc_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic sing;
  assign sing = (pa_x == pb_x) || (pb_x == pc_x) || (pa_x == pc_x);

  // divider operands
  logic signed [DIFF_W-1:0] dy_ab, dy_bc, dx_ab, dx_bc, dx_ca, den;
  logic signed [WIDE_W-1:0] num;
  assign dy_ab = DIFF_W'(pb_y) - DIFF_W'(pa_y);
  assign dy_bc = DIFF_W'(pc_y) - DIFF_W'(pb_y);
  assign dx_ab = DIFF_W'(pb_x) - DIFF_W'(pa_x);
  assign dx_bc = DIFF_W'(pc_x) - DIFF_W'(pb_x);
  assign dx_ca = DIFF_W'(pc_x) - DIFF_W'(pa_x);

  always_comb begin
    case (cmd.div_sel)
      SEL_BC: begin
        num = WIDE_W'(dy_bc) <<< SLOPE_FRAC;
        den = dx_bc;
      end
      SEL_SQ: begin
        num = (s_bc - s_ab) <<< SUM_FRAC;
        den = dx_ca;
      end
      default: begin
        num = WIDE_W'(dy_ab) <<< SLOPE_FRAC;
        den = dx_ab;
      end
    endcase
  end

  logic [DIFF_W-1:0] den_abs;
  logic [COORD_WIDTH:0] trial;
  assign den_abs = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
  assign trial   = {rem, quo[WIDE_W-1]};

  // multiplier operands
  logic signed [WIDE_W-1:0] m_a;
  logic signed [DIFF_W-1:0] m_b;
  logic [DIFF_W-1:0]        m_b_abs;
  logic [PROD_W-1:0]        shifted, clamped;
  assign m_a     = cmd.second ? inner : cs;
  assign m_b     = cmd.second ? (DIFF_W'(cur_x) - DIFF_W'(pa_x))
                              : (DIFF_W'(cur_x) - DIFF_W'(pb_x));
  assign m_b_abs = m_b[DIFF_W-1] ? DIFF_W'(-m_b) : DIFF_W'(m_b);
  assign shifted = cmd.second ? (prod >> OUTER_SH) : (prod >> SUM_FRAC);
  assign clamped = (shifted > CLAMP_LIM) ? CLAMP_LIM : shifted;

  logic signed [WIDE_W-1:0] sum_r;
  assign sum_r = (WIDE_W'(pa_y) <<< SUM_FRAC) + res + ROUND_HALF;

  // range count
  logic signed [DIFF_W-1:0] diff;
  logic [CNT_RAW_W-1:0]     cnt_raw;
  logic                     diff_pos, over;
  logic [CNT_W-1:0]         count;
  assign diff     = DIFF_W'(end_x) - DIFF_W'(start_x);
  assign diff_pos = !diff[DIFF_W-1];
  assign cnt_raw  = diff[DIFF_W-1:FRAC_BITS];
  assign over     = diff_pos && (cnt_raw > CNT_RAW_W'(MAX_POINTS));
  always_comb begin
    if (!diff_pos) count = '0;
    else if (over) count = CNT_W'(MAX_POINTS);
    else           count = cnt_raw[CNT_W-1:0];
  end

  logic signed [COORD_WIDTH-1:0] y_sat;
  always_comb begin
    if (y_round > Y_HI)      y_sat = Y_HI[COORD_WIDTH-1:0];
    else if (y_round < Y_LO) y_sat = Y_LO[COORD_WIDTH-1:0];
    else                     y_sat = y_round[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ab <= '0;
      s_bc <= '0;
      cs   <= '0;
    end else begin
      case (cmd.op)
        OP_DIV_INIT: begin
          quo     <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
          rem     <= '0;
          dvsr    <= den_abs[COORD_WIDTH-1:0];
          div_neg <= num[WIDE_W-1] ^ den[DIFF_W-1];
        end
        OP_DIV_STEP: begin
          if (trial >= {1'b0, dvsr}) begin
            rem <= COORD_WIDTH'(trial - {1'b0, dvsr});
            quo <= {quo[WIDE_W-2:0], 1'b1};
          end else begin
            rem <= trial[COORD_WIDTH-1:0];
            quo <= {quo[WIDE_W-2:0], 1'b0};
          end
        end
        OP_DIV_STORE: begin
          case (cmd.div_sel)
            SEL_BC:  s_bc <= div_neg ? -quo : quo;
            SEL_SQ:  cs   <= div_neg ? -quo : quo;
            default: s_ab <= div_neg ? -quo : quo;
          endcase
        end
        OP_LOAD: begin
          cur_x      <= start_x;
          left       <= count;
          trunc_flag <= over;
        end
        OP_M_SETUP: begin
          a_mag <= m_a[WIDE_W-1] ? WIDE_W'(-m_a) : WIDE_W'(m_a);
          b_mag <= m_b_abs[COORD_WIDTH-1:0];
          mneg  <= m_a[WIDE_W-1] ^ m_b[DIFF_W-1];
        end
        OP_MUL_LO:  plo  <= a_mag[HALF_W-1:0] * b_mag;
        OP_MUL_HI:  phi  <= a_mag[WIDE_W-1:HALF_W] * b_mag;
        OP_MUL_SUM: prod <= {phi, {HALF_W{1'b0}}} + PROD_W'(plo);
        OP_MUL_FIN: res  <= mneg ? -clamped[WIDE_W-1:0] : clamped[WIDE_W-1:0];
        OP_INNER:   inner <= res + s_ab;
        OP_ROUND:   y_round <= sum_r[WIDE_W-1:SUM_FRAC];
        OP_EMIT: begin
          x_value   <= cur_x;
          y_value   <= sing ? '0 : y_sat;
          last      <= (left == CNT_W'(1));
          singular  <= sing;
          truncated <= trunc_flag;
          cur_x     <= cur_x + X_STEP;
          left      <= left - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.op == OP_EMIT) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  assign status.cfg_hit    = cfg_we && (cfg_index inside {[REG_A_X:REG_C_Y]});
  assign status.count_zero = (count == '0);
  assign status.out_free   = !out_valid || !out_stall;
  assign status.last_point = (left == CNT_W'(1));

endmodule
`default_nettype wire

// ----- rtl/qfre_ctrl.sv -----
// Controller: sequences the refit divisions and the per-point evaluation.
`default_nettype none
`include "quadratic_fit_range_eval_top_assert.svh"
module qfre_ctrl import qfre_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t status,
  output logic         in_stall,
  output cmd_t         cmd
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DIV_INIT  = 13'b0000000000010,
    S_DIV_RUN   = 13'b0000000000100,
    S_DIV_STORE = 13'b0000000001000,
    S_M_SETUP   = 13'b0000000010000,
    S_MUL_LO    = 13'b0000000100000,
    S_MUL_HI    = 13'b0000001000000,
    S_MUL_SUM   = 13'b0000010000000,
    S_MUL_FIN   = 13'b0000100000000,
    S_INNER     = 13'b0001000000000,
    S_ROUND     = 13'b0010000000000,
    S_EMIT      = 13'b0100000000000,
    S_SPARE     = 13'b1000000000000
  } state_t;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t               state, state_next;
  div_sel_t             div_sel, div_sel_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 second, second_next;

  always_comb begin
    state_next   = state;
    div_sel_next = div_sel;
    div_cnt_next = div_cnt;
    second_next  = second;
    cmd          = '{op: OP_NONE, div_sel: div_sel, second: second};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (!status.count_zero) begin
            state_next  = S_M_SETUP;
            second_next = 1'b0;
          end
        end
      end
      S_DIV_INIT: begin
        cmd.op       = OP_DIV_INIT;
        div_cnt_next = '0;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.op       = OP_DIV_STEP;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_LAST) state_next = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        cmd.op = OP_DIV_STORE;
        case (div_sel)
          SEL_AB: begin
            div_sel_next = SEL_BC;
            state_next   = S_DIV_INIT;
          end
          SEL_BC: begin
            div_sel_next = SEL_SQ;
            state_next   = S_DIV_INIT;
          end
          default: begin
            div_sel_next = SEL_AB;
            state_next   = S_IDLE;
          end
        endcase
      end
      S_M_SETUP: begin
        cmd.op     = OP_M_SETUP;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        cmd.op     = OP_MUL_SUM;
        state_next = S_MUL_FIN;
      end
      S_MUL_FIN: begin
        cmd.op     = OP_MUL_FIN;
        state_next = second ? S_ROUND : S_INNER;
      end
      S_INNER: begin
        cmd.op      = OP_INNER;
        second_next = 1'b1;
        state_next  = S_M_SETUP;
      end
      S_ROUND: begin
        cmd.op     = OP_ROUND;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the point
        if (status.out_free) begin
          cmd.op      = OP_EMIT;
          second_next = 1'b0;
          state_next  = status.last_point ? S_IDLE : S_M_SETUP;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // a register write restarts the fit from the first division
    if (status.cfg_hit) begin
      state_next   = S_DIV_INIT;
      div_sel_next = SEL_AB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_sel <= SEL_AB;
      div_cnt <= '0;
      second  <= 1'b0;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
      div_cnt <= div_cnt_next;
      second  <= second_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  `QFRE_ASSERT_NEXT(a_emit_hold, clk, rst, (state == S_EMIT) && !status.out_free && !status.cfg_hit, state == S_EMIT)
  `QFRE_ASSERT_NEXT(a_cfg_refit, clk, rst, status.cfg_hit, (state == S_DIV_INIT) && (div_sel == SEL_AB))
  `QFRE_ASSERT_NEXT(a_div_done, clk, rst, (state == S_DIV_RUN) && (div_cnt == DIV_LAST) && !status.cfg_hit, state == S_DIV_STORE)
  `QFRE_ASSERT_NOW(a_load_idle, clk, rst, cmd.op == OP_LOAD, (state == S_IDLE) && in_valid)

endmodule
`default_nettype wire

// ----- rtl/quadratic_fit_range_eval_top.sv -----
// Top level of the three-point quadratic range evaluator.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------------
//  request   in         in_valid / in_stall    start_x, end_x
//  point     out        out_valid / out_stall  x_value, y_value, last, singular, truncated
//  config    in         cfg_we                 cfg_index, cfg_data
//
//  Each point runs two multiplies, each of setup, two 32-bit partial products,
//  sum and clamp; an inner sum lies between them, then round and emit follow.
//  A register write starts a refit of three 64-step serial divisions and
//  stalls requests until it ends; reset loads the reset fit directly.
//  A stalled output point holds the evaluation at its emit step; the next
//  request is taken while the final point of the previous one still waits.
`default_nettype none
module quadratic_fit_range_eval_top import qfre_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] start_x,
  input  wire logic signed [COORD_WIDTH-1:0] end_x,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      x_value,
  output logic signed [COORD_WIDTH-1:0]      y_value,
  output logic                               last,
  output logic                               singular,
  output logic                               truncated
);

  cmd_t    cmd;
  status_t status;

  // sequencing: refit divisions and per-point evaluation steps
  qfre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // arithmetic, point registers and the output register
  qfre_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_x   (start_x),
    .end_x     (end_x),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .x_value   (x_value),
    .y_value   (y_value),
    .last      (last),
    .singular  (singular),
    .truncated (truncated)
  );

endmodule
`default_nettype wire
